FILE: hw/rtl/psl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants of the positional sequence list
// Store geometry, operation and status codes, channel payloads, memory
// command bundle and sequencer states.
// ----------------------------------------------------------------------------
package psl_pkg;

   // store geometry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // capacity register
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_W-1:0]     wr_addr;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_W-1:0]     rd_addr;
   } mem_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_INS_WR,
      S_SHIFT_DN,
      S_GET_WAIT,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/psl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_mem: entry store of the list
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psl_mem (
   input  logic                            clock,
   input  psl_pkg::mem_cmd_type            mem_cmd,
   output logic [psl_pkg::DATA_WIDTH-1:0]  mem_rdata
);
   import psl_pkg::*;

   logic [DATA_WIDTH-1:0] store [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         mem_rdata <= store[mem_cmd.rd_addr];
      end
   end

endmodule

FILE: hw/rtl/psl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_ctrl: request sequencer of the positional sequence list
// Holds count and capacity, walks the entry store one entry per cycle to
// open or close a gap, and registers the response.
// ----------------------------------------------------------------------------
module psl_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  psl_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output psl_pkg::rsp_type                rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [psl_pkg::CAP_W-1:0]       csr_wr_data,
   output psl_pkg::mem_cmd_type            mem_cmd,
   input  logic [psl_pkg::DATA_WIDTH-1:0]  mem_rdata
);
   import psl_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CAP_W-1:0]      cap_ff;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic                  first_ff, first_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [8:0] pos_ext;
   logic [8:0] cnt_ext;
   logic       full;
   logic       in_range;

   assign pos_ext  = {1'b0, req_payload.position};
   assign cnt_ext  = 9'(cnt_ff);
   assign full     = (cnt_ext >= 9'(cap_ff)) || (cnt_ext >= 9'(DEPTH));
   assign in_range = pos_ext < cnt_ext;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      idx_ff       <= idx_in;
      first_ff     <= first_in;
      pend_addr_ff <= pend_addr_in;
      rd_ff        <= rd_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   // next state, memory commands and response
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      pend_addr_in = pend_addr_ff;
      rd_in        = rd_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      mem_cmd      = '0;

      // response slot drains when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in    = DATA_WIDTH'(req_payload.value);
               rd_in     = '0;
               status_in = STAT_OK;
               pend_in   = 1'b0;
               case (req_payload.op)
                  OP_INSERT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                        state_in  = S_DONE;
                     end else begin
                        // insert past the end appends
                        pos_in   = (pos_ext > cnt_ext) ? cnt_ff
                                                       : CNT_W'(req_payload.position);
                        idx_in   = cnt_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     if (!in_range) begin
                        status_in = STAT_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        idx_in   = CNT_W'(req_payload.position);
                        state_in = S_SHIFT_DN;
                     end
                  end
                  OP_GET: begin
                     if (!in_range) begin
                        status_in = STAT_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = ADDR_W'(req_payload.position);
                        state_in        = S_GET_WAIT;
                     end
                  end
                  default: begin
                     status_in = STAT_RANGE;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // move entries up: read idx-1 while writing the previous read to idx+1
         S_SHIFT_UP: begin
            mem_cmd.wr_en   = pend_ff;
            mem_cmd.wr_addr = pend_addr_ff;
            mem_cmd.wr_data = mem_rdata;
            if (idx_ff > pos_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = ADDR_W'(idx_ff - 1'b1);
               pend_in         = 1'b1;
               pend_addr_in    = ADDR_W'(idx_ff);
               idx_in          = idx_ff - 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_INS_WR;
            end
         end

         // drop the new word into the opened slot
         S_INS_WR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = ADDR_W'(pos_ff);
            mem_cmd.wr_data = val_ff;
            cnt_in          = cnt_ff + 1'b1;
            state_in        = S_DONE;
         end

         // move entries down; the first word read is the removed one
         S_SHIFT_DN: begin
            if (pend_ff) begin
               if (first_ff) begin
                  rd_in = mem_rdata;
               end else begin
                  mem_cmd.wr_en   = 1'b1;
                  mem_cmd.wr_addr = pend_addr_ff;
                  mem_cmd.wr_data = mem_rdata;
               end
            end
            if (idx_ff < cnt_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = ADDR_W'(idx_ff);
               pend_in         = 1'b1;
               first_in        = !pend_ff;
               pend_addr_in    = ADDR_W'(idx_ff - 1'b1);
               idx_in          = idx_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_GET_WAIT: begin
            rd_in    = mem_rdata;
            state_in = S_DONE;
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status      = status_ff;
               rsp_in.read_value  = 32'(rd_ff);
               rsp_in.entry_count = 5'(cnt_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/positional_sequence_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_sequence_list: ordered list of data words with positional access
// Insert, delete and get at a position over a 16-entry store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (op, position, value) under valid/ready.
//   rsp_* returns one response per request (status, read_value, entry_count)
//   from an output register under valid/ready.
//   csr_wr_en/csr_wr_data write the capacity limit; write it only while idle.
// Steps after acceptance, each ending in S_DONE, which registers the response:
//   insert:        S_SHIFT_UP, then S_INS_WR (position clamped to count)
//   delete:        S_SHIFT_DN
//   get:           S_GET_WAIT
//   refused ops:   straight to S_DONE
// One request is in work at a time; the next is taken the cycle after its
// response has been registered. The entry store moves one entry per cycle
// through its single read and single write port.
// Reset empties the list and sets the capacity limit to 16; the store itself
// is not cleared. A stalled receiver holds the response in the output
// register; a request may still be taken and is held until the slot frees.
// ----------------------------------------------------------------------------
module positional_sequence_list (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  psl_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output psl_pkg::rsp_type             rsp_payload,
   input  logic                         csr_wr_en,
   input  logic [psl_pkg::CAP_W-1:0]    csr_wr_data
);
   import psl_pkg::*;

   mem_cmd_type           mem_cmd;
   logic [DATA_WIDTH-1:0] mem_rdata;

   // sequencer
   psl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_cmd     (mem_cmd),
      .mem_rdata   (mem_rdata)
   );

   // entry store
   psl_mem u_mem (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_rdata (mem_rdata)
   );

endmodule

FILE: hw/rtl/psl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psl_checker: port-level checks of the positional sequence list
// Watches the response channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module psl_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input psl_pkg::rsp_type rsp_payload
);
   import psl_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // refused requests return no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STAT_OK) |-> rsp_payload.read_value == 32'd0)
      else $error("refused request returned data");

   // count never exceeds the store
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.entry_count <= 5'(DEPTH))
      else $error("entry count beyond store depth");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind positional_sequence_list psl_checker u_psl_checker (.*);
